[design/wgpm_pkg.sv]
// ----------------------------------------------------------------------------
// wgpm_pkg
// Shared types, constants and elaboration-time tables for the windowed
// gamma pixel map.
// ----------------------------------------------------------------------------
package wgpm_pkg;

	// default pixel width
	localparam int IN_BITS_DEF = 12;

	// register clamps and reset values
	localparam int GAMMA_MIN  = 80;
	localparam int GAMMA_MAX  = 200;
	localparam int LOW_MAX    = 2000;
	localparam int HIGH_MIN   = 2096;
	localparam int G_RESET    = 100;
	localparam int LOW_RESET  = 0;
	localparam int HIGH_RESET = 4095;

	// datapath widths
	localparam int G_W    = 8;
	localparam int LIM_W  = 16;
	localparam int LVL_W  = 8;
	localparam int NUM_W  = 24;
	localparam int D_W    = 19;
	localparam int DG_W   = 27;
	localparam int M_W    = 21;
	localparam int IP_W   = 3;
	localparam int FRAC_W = 16;
	localparam int F_W    = 17;
	localparam int IDX_W  = 2;

	// floor(x / 100) as (x * RECIP_100) >> RECIP_SHIFT, exact for x < 2^30
	localparam int RECIP_W     = 28;
	localparam int RECIP_SHIFT = 34;
	localparam logic [RECIP_W-1:0] RECIP_100 = 28'd171798692;
	localparam int PROD_W = DG_W + RECIP_W;

	// register indexes
	typedef enum logic [IDX_W-1:0] {
		REG_GAMMA = 2'd0,
		REG_LOW   = 2'd1,
		REG_HIGH  = 2'd2
	} reg_idx_t;

	// clamped register values
	typedef struct packed {
		logic [G_W-1:0]   gamma;
		logic [LIM_W-1:0] low;
		logic [LIM_W-1:0] high;
	} cfg_t;

	typedef logic [D_W-1:0]    dlog_tab_t [256];
	typedef logic [FRAC_W-1:0] root_tab_t [FRAC_W];

	// truncating Q16 log2 for 0..255
	function automatic logic [D_W-1:0] log2_q16(input int unsigned v);
		int unsigned n;
		logic [63:0] x;
		logic [31:0] res;
		n = 0;
		for (int i = 1; i < 8; i++)
			if ((v >> i) != 0)
				n = i;
		x = 64'(v) << (16 - n);
		res = 32'(n << 16);
		for (int b = 15; b >= 0; b--) begin
			x = (x * x) >> 16;
			if (x >= 64'h20000) begin
				x = x >> 1;
				res[b] = 1'b1;
			end
		end
		return res[D_W-1:0];
	endfunction

	// log2(255) - log2(j) for every j
	function automatic dlog_tab_t make_dlog_tab();
		dlog_tab_t t;
		for (int j = 0; j < 256; j++)
			t[j] = log2_q16(255) - log2_q16(j);
		return t;
	endfunction

	function automatic logic [31:0] isqrt64(input logic [63:0] v);
		logic [63:0] r;
		logic [63:0] bt;
		logic [63:0] rem;
		r = '0;
		rem = v;
		bt = 64'h1 << 62;
		while (bt > rem)
			bt = bt >> 2;
		while (bt != 0) begin
			if (rem >= r + bt) begin
				rem = rem - (r + bt);
				r = (r >> 1) + bt;
			end else begin
				r = r >> 1;
			end
			bt = bt >> 2;
		end
		return r[31:0];
	endfunction

	// Q16 roots 2^(-2^(b-16)) used by exp2 fraction bits
	function automatic root_tab_t make_root_tab();
		root_tab_t t;
		logic [63:0] c;
		c = 64'd32768;
		for (int b = FRAC_W - 1; b >= 0; b--) begin
			c = 64'(isqrt64(c << 16));
			t[b] = c[FRAC_W-1:0];
		end
		return t;
	endfunction

	localparam dlog_tab_t DLOG_TAB = make_dlog_tab();
	localparam root_tab_t ROOT_TAB = make_root_tab();

endpackage

[design/wgpm_pipe.sv]
// ----------------------------------------------------------------------------
// wgpm_pipe
// Datapath pipeline: window test, pipelined window divide, log table,
// gamma scale, bit-serial exp2 over sixteen stages and final scaling.
// ----------------------------------------------------------------------------
module wgpm_pipe #(
	parameter int IN_BITS = wgpm_pkg::IN_BITS_DEF
) (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      en,
	input  logic                      in_vld,
	input  logic [IN_BITS-1:0]        pixel,
	input  wgpm_pkg::cfg_t            cfg,
	output logic                      out_vld,
	output logic [wgpm_pkg::LVL_W-1:0] level
);
	import wgpm_pkg::*;

	// stage map: front, divide, log, gamma mult, recip mult, exp2 bits, scale
	localparam int NDIV    = 4;
	localparam int S_DIV   = 2;
	localparam int S_LOG   = S_DIV + NDIV;
	localparam int S_DG    = S_LOG + 1;
	localparam int S_M     = S_DG + 1;
	localparam int S_EXP   = S_M + 1;
	localparam int S_OUT   = S_EXP + FRAC_W;
	localparam int NS      = S_OUT;
	localparam int CMP_W   = LIM_W + 1;

	typedef struct packed {
		logic              lo_sat;
		logic              hi_sat;
		logic              zero;
		logic [NUM_W-1:0]  rem;
		logic [7:0]        j;
		logic [D_W-1:0]    d;
		logic [DG_W-1:0]   dg;
		logic [IP_W-1:0]   ip;
		logic [FRAC_W-1:0] fp;
		logic [F_W-1:0]    f;
		logic [LVL_W-1:0]  lvl;
	} stage_t;

	stage_t          stg_s [1:NS];
	stage_t          nxt   [1:NS];
	logic [NS:1]     vld_s;
	logic [LIM_W-1:0] range_w;

	assign range_w = cfg.high - cfg.low;

	// front: window compare and 255*(p-low)
	always_comb begin
		logic [CMP_W-1:0] p;
		logic [CMP_W-1:0] diff;
		nxt[1] = '0;
		p = CMP_W'(pixel);
		diff = p - CMP_W'(cfg.low);
		nxt[1].lo_sat = p < CMP_W'(cfg.low);
		nxt[1].hi_sat = p > CMP_W'(cfg.high);
		nxt[1].rem = (NUM_W'(diff[LIM_W-1:0]) << 8) - NUM_W'(diff[LIM_W-1:0]);
	end

	genvar k;
	generate
		// restoring divide, two quotient bits a stage
		for (k = 0; k < NDIV; k++) begin : g_div
			always_comb begin
				logic [NUM_W-1:0] r;
				logic [NUM_W-1:0] trial;
				nxt[S_DIV+k] = stg_s[S_DIV+k-1];
				r = stg_s[S_DIV+k-1].rem;
				for (int t = 0; t < 2; t++) begin
					trial = NUM_W'(range_w) << (7 - 2 * k - t);
					if (r >= trial) begin
						r = r - trial;
						nxt[S_DIV+k].j[7 - 2 * k - t] = 1'b1;
					end
				end
				nxt[S_DIV+k].rem = r;
			end
		end

		// exp2 of the fraction, one bit a stage from the top
		for (k = 0; k < FRAC_W; k++) begin : g_exp
			always_comb begin
				logic [2*F_W-1:0] pr;
				nxt[S_EXP+k] = stg_s[S_EXP+k-1];
				pr = (2*F_W)'(stg_s[S_EXP+k-1].f) *
					(2*F_W)'(ROOT_TAB[FRAC_W-1-k]);
				if (stg_s[S_EXP+k-1].fp[FRAC_W-1-k])
					nxt[S_EXP+k].f = F_W'(pr >> FRAC_W);
			end
		end
	endgenerate

	// log distance from the table
	always_comb begin
		nxt[S_LOG] = stg_s[S_LOG-1];
		nxt[S_LOG].zero = stg_s[S_LOG-1].j == 8'd0;
		nxt[S_LOG].d = DLOG_TAB[stg_s[S_LOG-1].j];
	end

	// distance times gamma
	always_comb begin
		nxt[S_DG] = stg_s[S_DG-1];
		nxt[S_DG].dg = DG_W'(stg_s[S_DG-1].d) * DG_W'(cfg.gamma);
	end

	// divide by 100 and split into integer and fraction; an integer part too wide for ip sets zero
	always_comb begin
		logic [PROD_W-1:0] pr;
		logic [M_W-1:0]    m;
		nxt[S_M] = stg_s[S_M-1];
		pr = PROD_W'(stg_s[S_M-1].dg) * PROD_W'(RECIP_100);
		m = M_W'(pr >> RECIP_SHIFT);
		if (m[M_W-1:FRAC_W+IP_W] != '0)
			nxt[S_M].zero = 1'b1;
		nxt[S_M].ip = m[FRAC_W+IP_W-1:FRAC_W];
		nxt[S_M].fp = m[FRAC_W-1:0];
		nxt[S_M].f = F_W'(1) << FRAC_W;
	end

	// scale to 8 bits and apply the window
	always_comb begin
		logic [NUM_W:0] pr;
		logic [LVL_W:0] top;
		nxt[S_OUT] = stg_s[S_OUT-1];
		pr = (NUM_W+1)'(stg_s[S_OUT-1].f) * (NUM_W+1)'(255);
		top = (LVL_W+1)'(pr >> FRAC_W);
		priority if (stg_s[S_OUT-1].lo_sat)
			nxt[S_OUT].lvl = '0;
		else if (stg_s[S_OUT-1].hi_sat)
			nxt[S_OUT].lvl = '1;
		else if (stg_s[S_OUT-1].zero)
			nxt[S_OUT].lvl = '0;
		else
			nxt[S_OUT].lvl = LVL_W'(top >> stg_s[S_OUT-1].ip);
	end

	// valid bits
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s <= '0;
		end else if (en) begin
			vld_s <= {vld_s[NS-1:1], in_vld};
		end
	end

	// stage payload
	always_ff @(posedge clk) begin
		if (en) begin
			for (int i = 1; i <= NS; i++)
				stg_s[i] <= nxt[i];
		end
	end

	assign out_vld = vld_s[NS];
	assign level   = stg_s[NS].lvl;

endmodule

[design/window_gamma_pixel_map.sv]
// ----------------------------------------------------------------------------
// window_gamma_pixel_map
// Windowed, gamma-corrected map from a raw sensor pixel to an 8-bit level.
// ----------------------------------------------------------------------------
// Pixels enter on pixel/pixel_valid and are taken at a clock edge where
// pixel_valid is high and pixel_stall is low. Levels leave on
// level/level_valid and are taken where level_valid is high and level_stall
// is low. Each pixel gives exactly one level, in order.
// Registers are written on the cfg port (cfg_valid, cfg_ready, cfg_index,
// cfg_data): 0 gamma in hundredths, 1 low limit, 2 high limit. cfg_ready is
// always high; write only while no pixel is in flight.
// One pixel is accepted every cycle while pixel_stall is low. The pipeline
// depth is set by the four-stage window divide and the sixteen-stage exp2
// multiplier chain.
// Reset clears all valid bits and loads gamma 1.00, window 0..4095.
// When level_stall is held, the last result is parked in a skid register
// while the pipeline moves once more; then pixel_stall rises and the whole
// pipeline holds until the parked level is transferred.
// ----------------------------------------------------------------------------
module window_gamma_pixel_map #(
	parameter int IN_BITS = wgpm_pkg::IN_BITS_DEF
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         pixel_valid,
	output logic                         pixel_stall,
	input  logic [IN_BITS-1:0]           pixel,
	output logic                         level_valid,
	input  logic                         level_stall,
	output logic [wgpm_pkg::LVL_W-1:0]   level,
	input  logic                         cfg_valid,
	output logic                         cfg_ready,
	input  logic [wgpm_pkg::IDX_W-1:0]   cfg_index,
	input  logic [wgpm_pkg::LIM_W-1:0]   cfg_data
);
	import wgpm_pkg::*;

	cfg_t             cfg_q;
	logic             skid_v_q;
	logic [LVL_W-1:0] skid_lvl_q;
	logic             en;
	logic             pv_out;
	logic [LVL_W-1:0] plevel;
	logic [G_W-1:0]   g_wr;

	assign cfg_ready = 1'b1;
	assign g_wr      = cfg_data[G_W-1:0];

	// register writes, clamped on the way in
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.gamma <= G_W'(G_RESET);
			cfg_q.low   <= LIM_W'(LOW_RESET);
			cfg_q.high  <= LIM_W'(HIGH_RESET);
		end else if (cfg_valid && cfg_ready) begin
			if (cfg_index == REG_GAMMA) begin
				if (g_wr < G_W'(GAMMA_MIN))
					cfg_q.gamma <= G_W'(GAMMA_MIN);
				else if (g_wr > G_W'(GAMMA_MAX))
					cfg_q.gamma <= G_W'(GAMMA_MAX);
				else
					cfg_q.gamma <= g_wr;
			end
			if (cfg_index == REG_LOW)
				cfg_q.low <= (cfg_data > LIM_W'(LOW_MAX)) ? LIM_W'(LOW_MAX) : cfg_data;
			if (cfg_index == REG_HIGH)
				cfg_q.high <= (cfg_data < LIM_W'(HIGH_MIN)) ? LIM_W'(HIGH_MIN) : cfg_data;
		end
	end

	// pipeline moves whenever the skid slot is free
	assign en          = !skid_v_q;
	assign pixel_stall = skid_v_q;

	wgpm_pipe #(
		.IN_BITS(IN_BITS)
	) u_pipe (
		.clk    (clk),
		.arst_n (arst_n),
		.en     (en),
		.in_vld (pixel_valid && !pixel_stall),
		.pixel  (pixel),
		.cfg    (cfg_q),
		.out_vld(pv_out),
		.level  (plevel)
	);

	// skid slot for a stalled result
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			skid_v_q <= 1'b0;
		end else if (skid_v_q) begin
			if (!level_stall)
				skid_v_q <= 1'b0;
		end else if (pv_out && level_stall) begin
			skid_v_q <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (!skid_v_q && pv_out && level_stall)
			skid_lvl_q <= plevel;
	end

	assign level_valid = skid_v_q || pv_out;
	assign level       = skid_v_q ? skid_lvl_q : plevel;

	// clamped registers stay in range
	a_gamma_range: assert property (@(posedge clk) disable iff (!arst_n)
		cfg_q.gamma >= G_W'(GAMMA_MIN) && cfg_q.gamma <= G_W'(GAMMA_MAX))
		else $error("gamma register out of clamp range");

	a_window_range: assert property (@(posedge clk) disable iff (!arst_n)
		cfg_q.low <= LIM_W'(LOW_MAX) && cfg_q.high >= LIM_W'(HIGH_MIN))
		else $error("window limits out of clamp range");

	// a stalled pipeline result is parked, not lost
	a_skid_fill: assert property (@(posedge clk) disable iff (!arst_n)
		(pv_out && !skid_v_q && level_stall) |=> skid_v_q && skid_lvl_q == $past(plevel))
		else $error("stalled result not captured in skid slot");

	// parked result holds until transferred
	a_skid_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(skid_v_q && level_stall) |=> skid_v_q && $stable(skid_lvl_q))
		else $error("skid slot changed while stalled");

endmodule

[verif/tb_window_gamma_pixel_map.sv]
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_window_gamma_pixel_map
// Self-checking bench for the windowed gamma pixel map: a directed table of
// pixels and register settings, then random streams under several window
// and gamma settings, with random gaps and stalls on both sides.
// ----------------------------------------------------------------------------
module tb_window_gamma_pixel_map;
	import wgpm_pkg::*;

	localparam int PIX_W      = 12;
	localparam int LATENCY    = 25;
	localparam int CYCLE_CAP  = 400000;
	localparam int NUM_PHASES = 6;

	logic               clk;
	logic               arst_n;
	logic               pixel_valid;
	logic               pixel_stall;
	logic [PIX_W-1:0]   pixel;
	logic               level_valid;
	logic               level_stall;
	logic [LVL_W-1:0]   level;
	logic               cfg_valid;
	logic               cfg_ready;
	logic [IDX_W-1:0]   cfg_index;
	logic [LIM_W-1:0]   cfg_data;

	window_gamma_pixel_map #(.IN_BITS(PIX_W)) dut (
		.clk(clk), .arst_n(arst_n),
		.pixel_valid(pixel_valid), .pixel_stall(pixel_stall), .pixel(pixel),
		.level_valid(level_valid), .level_stall(level_stall), .level(level),
		.cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
		.cfg_index(cfg_index), .cfg_data(cfg_data)
	);

	// mirror of the register file
	logic [G_W-1:0]   shadow_gamma;
	logic [LIM_W-1:0] shadow_low;
	logic [LIM_W-1:0] shadow_high;

	logic [LVL_W-1:0] level_queue [$];
	int errors;
	int cycles;
	bit hold_rx;

	// directed stimulus row: expected typed in only where obvious
	typedef struct {
		logic [PIX_W-1:0] pix;
		bit               known;
		logic [LVL_W-1:0] lvl;
	} pix_row_t;

	initial clk = 1'b0;
	always #6 clk = ~clk;

	// timeout watchdog
	initial begin
		cycles = 0;
		forever begin
			@(posedge clk);
			cycles++;
			if (cycles > CYCLE_CAP) begin
				$display("CHECKS FAILED");
				$finish;
			end
		end
	end

	function automatic logic [63:0] int_sqrt(input logic [63:0] v);
		logic [63:0] r, bt, rem;
		r = '0;
		rem = v;
		bt = 64'h1 << 62;
		while (bt > rem)
			bt = bt >> 2;
		while (bt != 0) begin
			if (rem >= r + bt) begin
				rem = rem - (r + bt);
				r = (r >> 1) + bt;
			end else begin
				r = r >> 1;
			end
			bt = bt >> 2;
		end
		return r;
	endfunction

	// truncating q16 base-2 logarithm of 1..255
	function automatic logic [31:0] q16_log2(input int unsigned v);
		int unsigned top;
		logic [63:0] x;
		logic [31:0] acc;
		top = 0;
		while (top < 31 && (v >> (top + 1)) != 0)
			top++;
		x = 64'(v) << (16 - top);
		acc = 32'(top) << 16;
		for (int b = 15; b >= 0; b--) begin
			x = (x * x) >> 16;
			if (x >= 64'h20000) begin
				x = x >> 1;
				acc[b] = 1'b1;
			end
		end
		return acc;
	endfunction

	// expected output level for a pixel under the mirrored registers
	function automatic logic [LVL_W-1:0] predict_level(input logic [PIX_W-1:0] p);
		int unsigned g, lo, hi, span, j, d, m, ip, fp;
		logic [63:0] root, scale;
		g = shadow_gamma;
		lo = shadow_low;
		hi = shadow_high;
		if (g < GAMMA_MIN) g = GAMMA_MIN;
		else if (g > GAMMA_MAX) g = GAMMA_MAX;
		if (lo > LOW_MAX) lo = LOW_MAX;
		if (hi < HIGH_MIN) hi = HIGH_MIN;
		span = hi - lo;
		if (p < lo)
			return '0;
		if (p > hi)
			return 8'd255;
		j = (255 * (p - lo)) / span;
		if (j > 255) j = 255;
		if (j == 0)
			return '0;
		d = q16_log2(255) - q16_log2(j);
		m = 32'((64'(d) * g) / 100);
		ip = m >> 16;
		fp = m & 32'hFFFF;
		if (ip >= 8)
			return '0;
		root = 64'd32768;
		scale = 64'd65536;
		for (int b = 15; b >= 0; b--) begin
			root = int_sqrt(root << 16);
			if (fp[b])
				scale = (scale * root) >> 16;
		end
		return 8'((64'd255 * scale) >> (16 + ip));
	endfunction

	// register write, only while idle
	task automatic write_reg(input reg_idx_t idx, input logic [LIM_W-1:0] val);
		cfg_index <= idx;
		cfg_data  <= val;
		cfg_valid <= 1'b1;
		do @(posedge clk); while (!cfg_ready);
		case (idx)
			REG_GAMMA: shadow_gamma = val[G_W-1:0];
			REG_LOW:   shadow_low = val;
			REG_HIGH:  shadow_high = val;
			default: ;
		endcase
		@(negedge clk);
		cfg_valid <= 1'b0;
	endtask

	// one pixel transfer, with a random lead-in gap when gaps is set
	task automatic send_pixel(input logic [PIX_W-1:0] p, input bit gaps);
		int gap;
		gap = gaps ? $urandom_range(0, 11) : 0;
		if (gap > 0) begin
			pixel_valid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		pixel <= p;
		pixel_valid <= 1'b1;
		do @(posedge clk); while (pixel_stall);
		level_queue.push_back(predict_level(p));
		@(negedge clk);
	endtask

	task automatic drain();
		pixel_valid <= 1'b0;
		while (level_queue.size() != 0)
			@(negedge clk);
		repeat (LATENCY + 4) @(negedge clk);
	endtask

	// output checker
	always @(posedge clk) begin
		if (arst_n && level_valid && !level_stall) begin
			if (level_queue.size() == 0) begin
				$display("%0t: unexpected level, expected none, actual %0d", $time, level);
				errors++;
			end else begin
				if (level !== level_queue[0]) begin
					$display("%0t: level mismatch, expected %0d, actual %0d",
						$time, level_queue[0], level);
					errors++;
				end
				void'(level_queue.pop_front());
			end
		end
	end

	// receiver stall, random per transfer, or a long forced hold
	initial begin
		int wait_n;
		level_stall = 1'b0;
		forever begin
			@(negedge clk);
			if (hold_rx) begin
				level_stall <= 1'b1;
			end else begin
				wait_n = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 11);
				if (wait_n > 0) begin
					level_stall <= 1'b1;
					repeat (wait_n - 1) @(negedge clk);
				end else begin
					level_stall <= 1'b0;
					do @(posedge clk); while (!(level_valid && !level_stall));
				end
			end
		end
	end

	pix_row_t directed [$];
	logic [PIX_W-1:0] rp;

	initial begin
		errors = 0;
		hold_rx = 1'b0;
		arst_n = 1'b0;
		pixel_valid = 1'b0;
		pixel = '0;
		cfg_valid = 1'b0;
		cfg_index = REG_GAMMA;
		cfg_data = '0;
		shadow_gamma = G_RESET;
		shadow_low = LOW_RESET;
		shadow_high = HIGH_RESET;
		repeat (3) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// directed table at reset settings: window 0..4095, gamma 1.00
		directed = '{
			'{12'd0, 1, 8'd0}, '{12'd4095, 1, 8'd255}, '{12'd1, 0, 8'd0},
			'{12'd16, 0, 8'd0}, '{12'd17, 0, 8'd0}, '{12'd2048, 0, 8'd0},
			'{12'd2730, 0, 8'd0}, '{12'd1365, 0, 8'd0}, '{12'd4094, 0, 8'd0},
			'{12'd4080, 0, 8'd0}, '{12'd3000, 0, 8'd0}, '{12'd100, 0, 8'd0}
		};
		foreach (directed[i]) begin
			if (directed[i].known && predict_level(directed[i].pix) !== directed[i].lvl) begin
				$display("%0t: table row %0d, expected %0d, actual %0d", $time, i,
					directed[i].lvl, predict_level(directed[i].pix));
				errors++;
			end
			send_pixel(directed[i].pix, 1'b0);
		end
		drain();

		// narrowest window, strongest gamma: bounds, outside, and raw out of range
		write_reg(REG_GAMMA, 16'd255);
		write_reg(REG_LOW, 16'hFFFF);
		write_reg(REG_HIGH, 16'd0);
		directed = '{
			'{12'd1999, 1, 8'd0}, '{12'd2000, 1, 8'd0}, '{12'd2096, 1, 8'd255},
			'{12'd2097, 1, 8'd255}, '{12'd2001, 0, 8'd0}, '{12'd2050, 0, 8'd0},
			'{12'd2095, 0, 8'd0}, '{12'd4095, 1, 8'd255}
		};
		foreach (directed[i]) begin
			if (directed[i].known && predict_level(directed[i].pix) !== directed[i].lvl) begin
				$display("%0t: table row %0d, expected %0d, actual %0d", $time, i,
					directed[i].lvl, predict_level(directed[i].pix));
				errors++;
			end
			send_pixel(directed[i].pix, 1'b0);
		end
		drain();

		// random phases over register settings, extremes first
		for (int ph = 0; ph < NUM_PHASES; ph++) begin
			case (ph)
				0: begin
					write_reg(REG_GAMMA, 16'd0);
					write_reg(REG_LOW, 16'd0);
					write_reg(REG_HIGH, 16'hFFFF);
				end
				1: begin
					write_reg(REG_GAMMA, 16'd200);
					write_reg(REG_LOW, 16'd2000);
					write_reg(REG_HIGH, 16'd2096);
				end
				default: begin
					write_reg(REG_GAMMA, 16'($urandom_range(0, 255)));
					write_reg(REG_LOW, ($urandom_range(0, 1)) ? 16'($urandom_range(0, 2500))
						: 16'($urandom));
					write_reg(REG_HIGH, ($urandom_range(0, 1)) ? 16'($urandom_range(1800, 4095))
						: 16'($urandom));
				end
			endcase

			// long receiver hold in one phase so the pipeline backs up
			if (ph == 2) begin
				fork
					begin
						hold_rx = 1'b1;
						repeat (80) @(posedge clk);
						hold_rx = 1'b0;
					end
				join_none
			end

			for (int k = 0; k < 90; k++) begin
				if (ph == 2 && k < 40) begin
					rp = PIX_W'($urandom);
					send_pixel(rp, 1'b0);
				end else begin
					case ($urandom_range(0, 3))
						0: rp = PIX_W'($urandom);
						1: rp = PIX_W'($urandom_range(1900, 2200));
						2: rp = PIX_W'($urandom_range(0, 64));
						default: rp = PIX_W'($urandom_range(4000, 4095));
					endcase
					send_pixel(rp, k % 30 >= 10);
				end
				// sender pause until the pipeline empties
				if (ph == 3 && k == 45) begin
					pixel_valid <= 1'b0;
					while (level_queue.size() != 0)
						@(negedge clk);
				end
			end
			drain();
		end

		if (errors == 0)
			$display("ALL CHECKS PASSED");
		else
			$display("CHECKS FAILED");
		$finish;
	end
endmodule

[window_gamma_pixel_map.f]
design/wgpm_pkg.sv
design/wgpm_pipe.sv
design/window_gamma_pixel_map.sv
verif/tb_window_gamma_pixel_map.sv
